// ===== rtl/sba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sba_pkg;

    localparam int NUM_SLOTS_DEF = 64;

    // Width of the result and input fields.
    localparam int CMD_W    = 3;
    localparam int ID_IN_W  = 8;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 6;
    localparam int OCTET_W  = 8;

    // The bitmap is scanned one digit of DIGIT_W bits per cycle.
    localparam int DIGIT_BITS = 4;
    localparam int DIGIT_W    = 1 << DIGIT_BITS;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC      = 3'd0,
        CMD_RELEASE    = 3'd1,
        CMD_LOAD_BEGIN = 3'd2,
        CMD_LOAD_ID    = 3'd3,
        CMD_LOAD_END   = 3'd4,
        CMD_SELECT     = 3'd5
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NONE_FREE = 3'd1,
        ST_RANGE     = 3'd2,
        ST_NOT_ALLOC = 3'd3,
        ST_DUP       = 3'd4
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/subnet_bitmap_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Subnet bitmap allocator: keeps one used bit for each of NUM_SLOTS /30 subnet slots
// (four addresses each, netmask 255.255.255.252), with slot 0 reserved after reset and
// after every end load. Each input word carries a command and a slot id and yields
// exactly one result word. Release, begin load, load id, end load and select are
// resolved in the cycle the word is accepted, and their result is offered on the next
// cycle. Allocate scans the bitmap for the lowest free slot one 16-bit digit per
// cycle, from digit 0 upward, and registers the first free slot it finds, or a
// none-free status after the last digit. The block works on one word at a time: a
// new input word is taken while no scan runs and the output register is empty or
// being emptied in the same cycle. A held result thus never blocks the next word
// once the consumer takes it.

module subnet_bitmap_allocator #(
    parameter int NUM_SLOTS = sba_pkg::NUM_SLOTS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,

    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [sba_pkg::CMD_W-1:0]      i_command,
    input  wire logic [sba_pkg::ID_IN_W-1:0]    i_req_slot,

    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [sba_pkg::STATUS_W-1:0]        o_status,
    output logic [sba_pkg::SLOT_W-1:0]          o_slot_id,
    output logic [sba_pkg::OCTET_W-1:0]         o_gateway_octet,
    output logic [sba_pkg::OCTET_W-1:0]         o_host_octet,
    output logic                                o_slot_used
);
    import sba_pkg::*;

    localparam int ID_W       = $clog2(NUM_SLOTS);
    localparam int NUM_DIGITS = (NUM_SLOTS + DIGIT_W - 1) / DIGIT_W;
    localparam int DIG_IDX_W  = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam int SCAN_W     = NUM_DIGITS * DIGIT_W;

    // Control state.
    t_state                 r_state, n_state;
    logic [NUM_SLOTS-1:0]   r_map, n_map;
    logic [DIG_IDX_W-1:0]   r_dig, n_dig;
    logic                   r_out_valid, n_out_valid;

    // Result register.
    t_status                r_status, n_status;
    logic [SLOT_W-1:0]      r_slot, n_slot;
    logic                   r_octets, n_octets;
    logic                   r_used, n_used;

    logic                   w_accept;
    logic                   w_in_range;
    logic [ID_W-1:0]        w_idx;
    logic                   w_bit;
    logic [SCAN_W-1:0]      w_scan;
    logic                   w_found;
    logic [DIGIT_BITS-1:0]  w_pos;
    logic [SLOT_W-1:0]      w_found_slot;
    t_cmd                   w_cmd;

    assign w_cmd      = t_cmd'(i_command);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_in_range = {1'b0, i_req_slot} < (ID_IN_W + 1)'(NUM_SLOTS);
    assign w_idx      = i_req_slot[ID_W-1:0];
    assign w_bit      = w_in_range && r_map[w_idx];

    // The scan sees slots past the end of the map as used, so they are never picked.
    always_comb begin
        w_scan                = '1;
        w_scan[NUM_SLOTS-1:0] = r_map;
    end

    sba_first_zero u_first_zero (
        .i_digit (w_scan[r_dig*DIGIT_W +: DIGIT_W]),
        .o_found (w_found),
        .o_pos   (w_pos)
    );

    assign w_found_slot = SLOT_W'({r_dig, w_pos});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_map       = r_map;
        n_dig       = r_dig;
        n_out_valid = r_out_valid && !i_out_ready;
        n_status    = r_status;
        n_slot      = r_slot;
        n_octets    = r_octets;
        n_used      = r_used;
        o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_OK;
                    n_slot      = '0;
                    n_octets    = 1'b0;
                    n_used      = 1'b0;
                    case (w_cmd)
                        CMD_ALLOC: begin
                            // Result comes from the scan.
                            n_out_valid = 1'b0;
                            n_dig       = '0;
                            n_state     = S_SCAN;
                        end
                        CMD_RELEASE: begin
                            if (!w_in_range) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_map[w_idx] = 1'b0;
                                n_slot       = i_req_slot[SLOT_W-1:0];
                            end
                        end
                        CMD_LOAD_BEGIN: begin
                            n_map = '0;
                        end
                        CMD_LOAD_ID: begin
                            if (!w_in_range) begin
                                n_map    = '0;
                                n_status = ST_RANGE;
                            end else begin
                                n_map[w_idx] = 1'b1;
                                n_status     = w_bit ? ST_DUP : ST_OK;
                                n_slot       = i_req_slot[SLOT_W-1:0];
                                n_used       = 1'b1;
                            end
                        end
                        CMD_LOAD_END: begin
                            n_map[0] = 1'b1;
                            n_used   = 1'b1;
                        end
                        CMD_SELECT: begin
                            if (!w_in_range) begin
                                n_status = ST_RANGE;
                            end else if (!w_bit) begin
                                n_status = ST_NOT_ALLOC;
                                n_slot   = i_req_slot[SLOT_W-1:0];
                            end else begin
                                n_slot   = i_req_slot[SLOT_W-1:0];
                                n_octets = 1'b1;
                                n_used   = 1'b1;
                            end
                        end
                        default: begin
                            // Unused commands leave the map alone and report zeros.
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // The output register is empty here: it was empty or being emptied when the word came in.
                if (w_found) begin
                    n_map[w_found_slot[ID_W-1:0]] = 1'b1;
                    n_status    = ST_OK;
                    n_slot      = w_found_slot;
                    n_octets    = 1'b1;
                    n_used      = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end else if (r_dig == DIG_IDX_W'(NUM_DIGITS - 1)) begin
                    n_status    = ST_NONE_FREE;
                    n_slot      = '0;
                    n_octets    = 1'b0;
                    n_used      = 1'b0;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_dig = r_dig + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map       <= NUM_SLOTS'(1);
            r_dig       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_map       <= n_map;
            r_dig       <= n_dig;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_slot   <= n_slot;
        r_octets <= n_octets;
        r_used   <= n_used;
    end

    // The octets are the slot id times four plus one or two, and zero otherwise.
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_slot_id       = r_slot;
    assign o_gateway_octet = r_octets ? {r_slot, 2'b01} : '0;
    assign o_host_octet    = r_octets ? {r_slot, 2'b10} : '0;
    assign o_slot_used     = r_used;

    // While the scan runs the output register stays empty and no word is taken.
    a_scan_blocks : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (!r_out_valid && !o_in_ready))
        else $error("scan overlaps a pending result or an accepted word");

    // An accepted allocate always starts a scan.
    a_alloc_scans : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_cmd == CMD_ALLOC)) |=> (r_state == S_SCAN))
        else $error("allocate did not start a scan");

    // Octets are only reported for a used slot and match the slot id.
    a_octets : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_gateway_octet != '0)) |->
            (o_slot_used && (o_gateway_octet[OCTET_W-1:2] == o_slot_id)
             && (o_status == ST_OK)))
        else $error("octets reported for an unused or mismatched slot");

    // A slot handed out by a successful allocate is marked used.
    a_alloc_marks : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) && w_found) |=> r_map[r_slot[ID_W-1:0]])
        else $error("allocated slot not marked in the map");

endmodule

`default_nettype wire

// ===== rtl/sba_first_zero.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sba_first_zero (
    input  wire logic [sba_pkg::DIGIT_W-1:0]    i_digit,
    output logic                                o_found,
    output logic [sba_pkg::DIGIT_BITS-1:0]      o_pos
);
    import sba_pkg::*;

    // Priority encoder for the lowest clear bit of one digit.
    always_comb begin
        o_found = 1'b0;
        o_pos   = '0;
        for (int i = DIGIT_W - 1; i >= 0; i--) begin
            if (!i_digit[i]) begin
                o_found = 1'b1;
                o_pos   = DIGIT_BITS'(i);
            end
        end
    end

endmodule

`default_nettype wire
